// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; the using module provides clk and rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define FPP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpp: same-cycle check failed");

// next-cycle implication, checked out of reset
`define FPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpp: next-cycle check failed");

`endif

// ----- src/fpp_pkg.sv -----
// ----------------------------------------------------------------------------
// fpp_pkg
// Types and constants of the FIFO page pool with dirty write-back.
// ----------------------------------------------------------------------------
package fpp_pkg;

  // request kinds
  localparam logic [1:0] REQ_GET    = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_RENAME = 2'd2;

  localparam int unsigned REQ_W     = 2;
  localparam int unsigned PAGE_W    = 16;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned LIMIT_W   = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// ----- src/fifo_page_pool_dirty_writeback.sv -----
// ----------------------------------------------------------------------------
// fifo_page_pool_dirty_writeback
// Page buffer pool with first-in first-out replacement and dirty write-back.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the request kind (get,
//   write, rename), s_tdata the table, page and new table. Every request gives
//   exactly one result on the m_ stream: hit / writeback / direct-write flags
//   in m_tuser, and slot, evicted tag and both running counters in m_tdata.
//   Write the pool limit via cfg_we / cfg_wdata only while idle; not enforced.
// Timing:
//   Entry tags live in one synchronous memory. A request scans the occupied
//   queue from the oldest entry, one read a cycle, and stops on the first live
//   match; rename rewrites entries in place behind the read pointer. At most
//   POOL_DEPTH entries are examined; a rename onto itself or an unused kind
//   skips the scan. The insert or dirty mark is written back in the final
//   cycle.
// Reset:
//   rst empties the pool, clears both counters and sets the limit to 16.
// Stall:
//   The result waits in an output register; the next request is taken the
//   cycle after it loads and scanned meanwhile, and the block holds in its
//   final step until the receiver frees the register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_page_pool_dirty_writeback #(
  parameter int unsigned POOL_DEPTH    = 16,
  parameter int unsigned TABLE_ID_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  // configuration: pool_limit
  input  logic                            cfg_we,
  input  logic [fpp_pkg::LIMIT_W-1:0]     cfg_wdata,
  // request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // table_id, page_number, new_table_id (lowest first), zero padded
  input  logic [((2 * TABLE_ID_BITS + fpp_pkg::PAGE_W + 7) / 8) * 8 - 1:0] s_tdata,
  // req_type
  input  logic [fpp_pkg::REQ_W-1:0]       s_tuser,
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // slot, evicted_table, evicted_page, reads_total, writes_total (lowest
  // first), zero padded
  output logic [(($clog2(POOL_DEPTH) + TABLE_ID_BITS + fpp_pkg::PAGE_W
                 + 2 * fpp_pkg::CNT_W + 7) / 8) * 8 - 1:0] m_tdata,
  // hit, writeback, direct_write (lowest first)
  output logic [2:0]                      m_tuser
);

  localparam int unsigned T       = TABLE_ID_BITS;
  localparam int unsigned PW      = fpp_pkg::PAGE_W;
  localparam int unsigned CW      = fpp_pkg::CNT_W;
  localparam int unsigned SLOT_W  = $clog2(POOL_DEPTH);
  localparam int unsigned OCC_W   = $clog2(POOL_DEPTH + 1);
  localparam int unsigned CMP_W   = (OCC_W > fpp_pkg::LIMIT_W) ? OCC_W : fpp_pkg::LIMIT_W;
  localparam int unsigned IN_DW   = T + PW + T;
  localparam int unsigned OUT_DW  = SLOT_W + T + PW + CW + CW;
  localparam int unsigned OUT_DB  = ((OUT_DW + 7) / 8) * 8;
  // memory word: deleted, dirty, page, table (lowest first)
  localparam int unsigned W_DEL   = 0;
  localparam int unsigned W_DIRTY = 1;
  localparam int unsigned W_PG_LO = 2;
  localparam int unsigned W_TB_LO = W_PG_LO + PW;
  localparam int unsigned WORD_W  = W_TB_LO + T;

  localparam logic [SLOT_W:0]   DEPTH_X = (SLOT_W + 1)'(POOL_DEPTH);
  localparam logic [CMP_W-1:0]  DEPTH_C = CMP_W'(POOL_DEPTH);

  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W:0] sum);
    logic [SLOT_W:0] red;
    red = (sum >= DEPTH_X) ? (sum - DEPTH_X) : sum;
    return red[SLOT_W-1:0];
  endfunction

  // control state
  fpp_pkg::state_t state, state_next;
  logic [SLOT_W-1:0]          oldest, oldest_next;
  logic [OCC_W-1:0]           occupancy, occupancy_next;
  logic [CW-1:0]              read_counter, read_counter_next;
  logic [CW-1:0]              write_counter, write_counter_next;
  logic [fpp_pkg::LIMIT_W-1:0] pool_limit;
  logic [OCC_W-1:0]           scan_pos;
  logic                       rd_vld, rd_first, found;

  // payload
  logic [fpp_pkg::REQ_W-1:0]  q_req;
  logic [T-1:0]               q_tbl, q_ntbl;
  logic [PW-1:0]              q_pg;
  logic [SLOT_W-1:0]          rd_slot, found_slot;
  logic [WORD_W-1:0]          rd_data, old_word;

  logic [WORD_W-1:0] mem [POOL_DEPTH];

  // handshake and step control
  logic                accept, out_free, fin_go, issue, stop_hit, scan_need;
  logic [SLOT_W-1:0]   rd_addr;
  logic                mem_we;
  logic [SLOT_W-1:0]   mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;

  // fields of the word under compare
  logic [T-1:0]        rd_tbl;
  logic [PW-1:0]       rd_pg;
  logic                cmp_match;

  // result
  logic                res_hit, res_wb, res_direct;
  logic [SLOT_W-1:0]   res_slot, ins_slot;
  logic [T-1:0]        res_evt;
  logic [PW-1:0]       res_evp;
  logic [CMP_W-1:0]    lim_ext, lim_eff;
  logic                evict_need;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign fin_go   = (state == fpp_pkg::ST_FINISH) && out_free;

  // skip the scan where a request touches no entry
  always_comb begin
    unique case (s_tuser) inside
      fpp_pkg::REQ_GET, fpp_pkg::REQ_WRITE: scan_need = 1'b1;
      fpp_pkg::REQ_RENAME: scan_need = (s_tdata[T-1:0] != s_tdata[IN_DW-1:T+PW]);
      default: scan_need = 1'b0;
    endcase
  end

  assign rd_tbl    = rd_data[W_TB_LO +: T];
  assign rd_pg     = rd_data[W_PG_LO +: PW];
  assign cmp_match = rd_vld && !rd_data[W_DEL] && (rd_tbl == q_tbl) && (rd_pg == q_pg);
  assign stop_hit  = (state == fpp_pkg::ST_SCAN) && (q_req != fpp_pkg::REQ_RENAME) && cmp_match;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fpp_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = scan_need ? fpp_pkg::ST_SCAN : fpp_pkg::ST_FINISH;
        end
      end
      fpp_pkg::ST_SCAN: begin
        if (stop_hit || !(scan_pos < occupancy)) begin
          state_next = fpp_pkg::ST_FINISH;
        end
      end
      fpp_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = fpp_pkg::ST_IDLE;
        end
      end
      default: state_next = fpp_pkg::ST_IDLE;
    endcase
  end

  // step outputs
  always_comb begin
    s_tready = 1'b0;
    issue    = 1'b0;
    unique case (state)
      fpp_pkg::ST_IDLE:   s_tready = 1'b1;
      fpp_pkg::ST_SCAN:   issue    = (scan_pos < occupancy) && !stop_hit;
      fpp_pkg::ST_FINISH: ;
      default: ;
    endcase
  end

  assign rd_addr = wrap_slot({1'b0, oldest} + (SLOT_W + 1)'(scan_pos));

  // effective limit: zero counts as one, saturate at the pool depth
  always_comb begin
    lim_ext = CMP_W'(pool_limit);
    if (lim_ext == '0) begin
      lim_eff = CMP_W'(1);
    end else if (lim_ext > DEPTH_C) begin
      lim_eff = DEPTH_C;
    end else begin
      lim_eff = lim_ext;
    end
  end

  assign evict_need = CMP_W'(occupancy) >= lim_eff;
  // new tail lands at oldest + occupancy whether or not the head is dropped
  assign ins_slot   = wrap_slot({1'b0, oldest} + (SLOT_W + 1)'(occupancy));

  // result and queue update of the final step
  always_comb begin
    res_hit            = 1'b0;
    res_slot           = '0;
    res_wb             = 1'b0;
    res_evt            = '0;
    res_evp            = '0;
    res_direct         = 1'b0;
    read_counter_next  = read_counter;
    write_counter_next = write_counter;
    oldest_next        = oldest;
    occupancy_next     = occupancy;
    unique case (q_req)
      fpp_pkg::REQ_GET: begin
        if (found) begin
          res_hit  = 1'b1;
          res_slot = found_slot;
        end else begin
          read_counter_next = read_counter + CW'(1);
          res_slot          = ins_slot;
          if (evict_need) begin
            oldest_next = wrap_slot({1'b0, oldest} + (SLOT_W + 1)'(1));
            if (!old_word[W_DEL] && old_word[W_DIRTY]) begin
              res_wb             = 1'b1;
              res_evt            = old_word[W_TB_LO +: T];
              res_evp            = old_word[W_PG_LO +: PW];
              write_counter_next = write_counter + CW'(1);
            end
          end else begin
            occupancy_next = occupancy + OCC_W'(1);
          end
        end
      end
      fpp_pkg::REQ_WRITE: begin
        if (found) begin
          res_hit  = 1'b1;
          res_slot = found_slot;
        end else begin
          res_direct         = 1'b1;
          write_counter_next = write_counter + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // memory writes: rename rewrites behind the read pointer, the final step
  // inserts a clean entry or marks a hit dirty
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_slot;
    mem_wdata = rd_data;
    if ((state == fpp_pkg::ST_SCAN) && (q_req == fpp_pkg::REQ_RENAME) && rd_vld) begin
      if (rd_tbl == q_ntbl) begin
        mem_we           = 1'b1;
        mem_wdata[W_DEL] = 1'b1;
      end else if (rd_tbl == q_tbl) begin
        mem_we                  = 1'b1;
        mem_wdata[W_TB_LO +: T] = q_ntbl;
      end
    end else if (fin_go && (q_req == fpp_pkg::REQ_GET) && !found) begin
      mem_we    = 1'b1;
      mem_waddr = ins_slot;
      mem_wdata = {q_tbl, q_pg, 1'b0, 1'b0};
    end else if (fin_go && (q_req == fpp_pkg::REQ_WRITE) && found) begin
      mem_we    = 1'b1;
      mem_waddr = found_slot;
      mem_wdata = {q_tbl, q_pg, 1'b1, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fpp_pkg::ST_IDLE;
      oldest        <= '0;
      occupancy     <= '0;
      read_counter  <= '0;
      write_counter <= '0;
      pool_limit    <= fpp_pkg::LIMIT_RESET;
      scan_pos      <= '0;
      rd_vld        <= 1'b0;
      rd_first      <= 1'b0;
      found         <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= issue;
      rd_first <= issue && (scan_pos == '0);
      if (cfg_we) begin
        pool_limit <= cfg_wdata;
      end
      if (accept) begin
        scan_pos <= '0;
        found    <= 1'b0;
      end else if (issue) begin
        scan_pos <= scan_pos + OCC_W'(1);
      end
      if (stop_hit) begin
        found <= 1'b1;
      end
      if (fin_go) begin
        oldest        <= oldest_next;
        occupancy     <= occupancy_next;
        read_counter  <= read_counter_next;
        write_counter <= write_counter_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      q_req  <= s_tuser;
      q_tbl  <= s_tdata[T-1:0];
      q_pg   <= s_tdata[T+PW-1:T];
      q_ntbl <= s_tdata[IN_DW-1:T+PW];
    end
    rd_slot <= rd_addr;
    if (stop_hit) begin
      found_slot <= rd_slot;
    end
    // hold the head entry for a possible eviction
    if (rd_vld && rd_first) begin
      old_word <= rd_data;
    end
    if (fin_go) begin
      m_tdata <= OUT_DB'({write_counter_next, read_counter_next, res_evp, res_evt, res_slot});
      m_tuser <= {res_direct, res_wb, res_hit};
    end
  end

  `FPP_ASSERT_IMP(a_occ_bound, 1'b1, occupancy <= OCC_W'(POOL_DEPTH))
  `FPP_ASSERT_IMP(a_no_write_idle, mem_we, state != fpp_pkg::ST_IDLE)
  `FPP_ASSERT_NEXT(a_finish_loads, fin_go, m_tvalid && (state == fpp_pkg::ST_IDLE))
  `FPP_ASSERT_IMP(a_rename_no_hit, found, q_req != fpp_pkg::REQ_RENAME)

endmodule

// ----- verif/tb_fifo_page_pool_dirty_writeback.sv -----
// ----------------------------------------------------------------------------
// tb_fifo_page_pool_dirty_writeback
// Self-checking bench for the FIFO page pool. A short table of get, write,
// rename and unused requests runs first. Random traffic follows over a series
// of pool limits, including zero, the full depth and values above it. Every
// result is checked field by field against a local pool model (typed in for
// fixed rows), with random gaps on requests and random back-pressure on results.
// ----------------------------------------------------------------------------
module tb_fifo_page_pool_dirty_writeback;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD     = 2;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned POOL_DEPTH     = 16;
  localparam int unsigned REQ_DATA_W     = 32;
  localparam int unsigned RES_DATA_W     = 96;
  localparam int unsigned SETTLE_CYCLES  = 25;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned ITEMS_PER_STEP = 183;
  localparam int unsigned LIMIT_STEPS    = 10;
  localparam int unsigned DIRECTED_ROWS  = 22;
  localparam int unsigned REPORT_MAX     = 10;
  localparam logic [fpp_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  table_id;
    logic [15:0] page;
    logic [7:0]  new_table;
  } page_req_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic        writeback;
    logic [7:0]  ev_table;
    logic [15:0] ev_page;
    logic        direct;
    logic [31:0] reads;
    logic [31:0] writes;
  } page_res_t;

  typedef struct packed {
    page_req_t req;
    logic      fixed;      // result typed in below rather than predicted
    page_res_t res;
  } directed_row_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          cfg_we    = 1'b0;
  logic [fpp_pkg::LIMIT_W-1:0]   cfg_wdata = '0;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [REQ_DATA_W-1:0]         s_tdata   = '0;
  logic [fpp_pkg::REQ_W-1:0]     s_tuser   = '0;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [RES_DATA_W-1:0]         m_tdata;
  logic [2:0]                    m_tuser;

  // pool model
  logic [7:0]   pool_tbl   [POOL_DEPTH];
  logic [15:0]  pool_pg    [POOL_DEPTH];
  bit           pool_dirty [POOL_DEPTH];
  bit           pool_dead  [POOL_DEPTH];
  int unsigned  head_slot  = 0;
  int unsigned  fill       = 0;
  logic [31:0]  read_cnt   = '0;
  logic [31:0]  write_cnt  = '0;
  logic [4:0]   limit_reg  = fpp_pkg::LIMIT_RESET;

  page_res_t    pending_results [$];
  int unsigned  mismatch_count = 0;
  int unsigned  results_seen   = 0;
  int unsigned  quiet_cycles   = 0;
  int unsigned  recv_wait      = 0;
  bit           recv_calm      = 1'b0;
  bit           send_calm      = 1'b0;
  logic [7:0]   recent_table   = '0;
  logic [15:0]  recent_page    = '0;

  logic [4:0] limit_steps [LIMIT_STEPS] = '{
    5'd1, 5'd31, 5'd0, 5'd4, 5'd2, 5'd17, 5'd16, 5'd8, 5'd3, 5'd12
  };

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{fpp_pkg::REQ_GET,    8'h00, 16'h0000, 8'h00}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 8'h00, 16'h0000, 1'b0, 32'd1, 32'd0}},
    '{'{fpp_pkg::REQ_GET,    8'h00, 16'h0000, 8'h00}, 1'b1,
      '{1'b1, 4'd0, 1'b0, 8'h00, 16'h0000, 1'b0, 32'd1, 32'd0}},
    '{'{fpp_pkg::REQ_WRITE,  8'h00, 16'h0000, 8'h00}, 1'b1,
      '{1'b1, 4'd0, 1'b0, 8'h00, 16'h0000, 1'b0, 32'd1, 32'd0}},
    '{'{fpp_pkg::REQ_WRITE,  8'hFF, 16'hFFFF, 8'hFF}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 8'h00, 16'h0000, 1'b1, 32'd1, 32'd1}},
    '{'{fpp_pkg::REQ_GET,    8'hFF, 16'hFFFF, 8'hFF}, 1'b1,
      '{1'b0, 4'd1, 1'b0, 8'h00, 16'h0000, 1'b0, 32'd2, 32'd1}},
    // unused request kind leaves the pool alone
    '{'{REQ_UNUSED,          8'hFF, 16'hFFFF, 8'hFF}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 8'h00, 16'h0000, 1'b0, 32'd2, 32'd1}},
    // rename onto itself is a no-op
    '{'{fpp_pkg::REQ_RENAME, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 8'h00, 16'h0000, 1'b0, 32'd2, 32'd1}},
    '{'{fpp_pkg::REQ_GET,    8'hFF, 16'hFFFF, 8'h00}, 1'b1,
      '{1'b1, 4'd1, 1'b0, 8'h00, 16'h0000, 1'b0, 32'd2, 32'd1}},
    // table 0 takes the name of table 255, whose entry is deleted
    '{'{fpp_pkg::REQ_RENAME, 8'h00, 16'h1234, 8'hFF}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 8'h00, 16'h0000, 1'b0, 32'd2, 32'd1}},
    '{'{fpp_pkg::REQ_GET,    8'hFF, 16'hFFFF, 8'h00}, 1'b0, '0},
    '{'{fpp_pkg::REQ_GET,    8'hFF, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{fpp_pkg::REQ_WRITE,  8'h00, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{fpp_pkg::REQ_WRITE,  8'hFF, 16'hFFFF, 8'h00}, 1'b0, '0},
    '{'{fpp_pkg::REQ_GET,    8'h55, 16'hAAAA, 8'hAA}, 1'b0, '0},
    '{'{fpp_pkg::REQ_GET,    8'hAA, 16'h5555, 8'h55}, 1'b0, '0},
    '{'{fpp_pkg::REQ_WRITE,  8'hAA, 16'h5555, 8'h00}, 1'b0, '0},
    '{'{fpp_pkg::REQ_RENAME, 8'hAA, 16'h0000, 8'h55}, 1'b0, '0},
    '{'{fpp_pkg::REQ_GET,    8'h55, 16'hAAAA, 8'h00}, 1'b0, '0},
    '{'{fpp_pkg::REQ_GET,    8'h55, 16'h5555, 8'h00}, 1'b0, '0},
    '{'{fpp_pkg::REQ_RENAME, 8'h55, 16'hFFFF, 8'h00}, 1'b0, '0},
    '{'{REQ_UNUSED,          8'h00, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{fpp_pkg::REQ_WRITE,  8'h00, 16'hFFFF, 8'hFF}, 1'b0, '0}
  };

  fifo_page_pool_dirty_writeback dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // Mostly no gap, a few short ones and the odd long one; none while calm.
  function automatic int unsigned draw_gap(input bit calm);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one request to the pool model and return the result it gives.
  function automatic page_res_t predict_pool(input page_req_t rq);
    page_res_t   res;
    int unsigned lim, idx, hit_slot, i;
    bit          found;
    res      = '0;
    found    = 1'b0;
    hit_slot = 0;
    if (rq.kind == fpp_pkg::REQ_GET || rq.kind == fpp_pkg::REQ_WRITE) begin
      // oldest live match wins
      for (i = 0; i < fill; i++) begin
        idx = (head_slot + i) % POOL_DEPTH;
        if (!found && !pool_dead[idx] && pool_tbl[idx] == rq.table_id &&
            pool_pg[idx] == rq.page) begin
          found    = 1'b1;
          hit_slot = idx;
        end
      end
    end
    case (rq.kind)
      fpp_pkg::REQ_GET: begin
        if (found) begin
          res.hit  = 1'b1;
          res.slot = hit_slot[3:0];
        end else begin
          read_cnt = read_cnt + 1;
          lim = (limit_reg == 0) ? 1 : ((limit_reg > POOL_DEPTH) ? POOL_DEPTH : limit_reg);
          // evict a single entry even when the limit has dropped further
          if (fill >= lim) begin
            if (!pool_dead[head_slot] && pool_dirty[head_slot]) begin
              res.writeback = 1'b1;
              res.ev_table  = pool_tbl[head_slot];
              res.ev_page   = pool_pg[head_slot];
              write_cnt     = write_cnt + 1;
            end
            head_slot = (head_slot + 1) % POOL_DEPTH;
            fill      = fill - 1;
          end
          idx             = (head_slot + fill) % POOL_DEPTH;
          pool_tbl[idx]   = rq.table_id;
          pool_pg[idx]    = rq.page;
          pool_dirty[idx] = 1'b0;
          pool_dead[idx]  = 1'b0;
          fill            = fill + 1;
          res.slot        = idx[3:0];
        end
      end
      fpp_pkg::REQ_WRITE: begin
        if (found) begin
          res.hit              = 1'b1;
          res.slot             = hit_slot[3:0];
          pool_dirty[hit_slot] = 1'b1;
        end else begin
          res.direct = 1'b1;
          write_cnt  = write_cnt + 1;
        end
      end
      fpp_pkg::REQ_RENAME: begin
        if (rq.table_id != rq.new_table) begin
          for (i = 0; i < fill; i++) begin
            idx = (head_slot + i) % POOL_DEPTH;
            if (pool_tbl[idx] == rq.new_table) pool_dead[idx] = 1'b1;
            else if (pool_tbl[idx] == rq.table_id) pool_tbl[idx] = rq.new_table;
          end
        end
      end
      default: ;
    endcase
    res.reads  = read_cnt;
    res.writes = write_cnt;
    return res;
  endfunction

  // Small tag space so that hits, dirty evictions and renames come often;
  // now and then a full-range value for the bit coverage.
  function automatic page_req_t random_request();
    page_req_t   rq;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      rq.kind = fpp_pkg::REQ_GET;
    else if (pick < 78) rq.kind = fpp_pkg::REQ_WRITE;
    else if (pick < 94) rq.kind = fpp_pkg::REQ_RENAME;
    else                rq.kind = REQ_UNUSED;
    rq.table_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    rq.page     = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    rq.new_table = (rq.kind == fpp_pkg::REQ_RENAME && $urandom_range(0, 9) != 0) ?
                   8'($urandom_range(0, 3)) : 8'($urandom);
    // revisit the page fetched last
    if (rq.kind != fpp_pkg::REQ_RENAME && $urandom_range(0, 2) == 0) begin
      rq.table_id = recent_table;
      rq.page     = recent_page;
    end
    if (rq.kind == fpp_pkg::REQ_GET) begin
      recent_table = rq.table_id;
      recent_page  = rq.page;
    end
    return rq;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_request(input page_req_t rq, input logic fixed,
                              input page_res_t fixed_res);
    int unsigned gap;
    page_res_t   predicted;
    gap = draw_gap(send_calm);
    if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= rq.kind;
    s_tdata  <= {rq.new_table, rq.page, rq.table_id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_pool(rq);
    pending_results.insert(pending_results.size(), fixed ? fixed_res : predicted);
    @(negedge clk);
  endtask

  // Hold requests until every pending result has been transferred.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_pool_limit(input logic [4:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_reg = value;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, name, want, got);
    end
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_wait != 0) begin
      m_tready  <= 1'b0;
      recv_wait <= recv_wait - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 149) == 0) recv_calm <= !recv_calm;
      if (!recv_calm && $urandom_range(0, 2) == 0) recv_wait <= draw_gap(1'b0);
    end
  end

  always @(posedge clk) begin : result_check
    page_res_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("result %0d: transfer with nothing pending", results_seen);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          check_field("hit",           32'(want.hit),       32'(m_tuser[0]));
          check_field("writeback",     32'(want.writeback), 32'(m_tuser[1]));
          check_field("direct_write",  32'(want.direct),    32'(m_tuser[2]));
          check_field("slot",          32'(want.slot),      32'(m_tdata[3:0]));
          check_field("evicted_table", 32'(want.ev_table),  32'(m_tdata[11:4]));
          check_field("evicted_page",  32'(want.ev_page),   32'(m_tdata[27:12]));
          check_field("reads_total",   want.reads,          m_tdata[59:28]);
          check_field("writes_total",  want.writes,         m_tdata[91:60]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].res);
    drain_results();

    foreach (limit_steps[p]) begin
      set_pool_limit(limit_steps[p]);
      for (int n = 0; n < ITEMS_PER_STEP; n++) begin
        send_request(random_request(), 1'b0, '0);
        if ($urandom_range(0, 149) == 0) drain_results();
      end
      drain_results();
    end

    if (mismatch_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/fpp_pkg.sv
src/fifo_page_pool_dirty_writeback.sv
verif/tb_fifo_page_pool_dirty_writeback.sv
